/* hw/rtl/xild_pkg.sv */
// Package for the x86 instruction length decoder: constants, types and byte-class functions.
`default_nettype none
package xild_pkg;

	localparam int WINDOW_BYTES = 15;
	localparam int NUM_LANES = 16;
	localparam int WIN_BITS = 8 * 16;

	localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
	localparam logic [7:0] PFX_OSZ = 8'h66;
	localparam logic [7:0] PFX_ASZ = 8'h67;
	localparam logic [7:0] OP_VEX3 = 8'hC4;
	localparam logic [7:0] OP_VEX2 = 8'hC5;
	localparam logic [7:0] OP_MAP38 = 8'h38;
	localparam logic [7:0] OP_MAP3A = 8'h3A;
	localparam logic [7:0] OP_GRP3B = 8'hF6;
	localparam logic [7:0] OP_GRP3V = 8'hF7;
	localparam logic [7:0] OP_LAST_ALU = 8'h3D;
	localparam logic [7:0] PFX_LOCK = 8'hF0;

	localparam logic [0:0] REG_LONG_MODE = 1'b0;

	// What one lane finds about the byte at its position.
	typedef struct packed {
		logic       is_prefix;
		logic       is_osz;
		logic       is_asz;
		logic       is_rex;
		logic       rex_w;
		logic [3:0] modrm_len;
	} lane_info_t;

	typedef lane_info_t [NUM_LANES-1:0] lane_vec_t;

	// Length of ModRM with SIB and displacement, given the ModRM byte and the next byte.
	function automatic logic [3:0] modrm_size(input logic [7:0] m, input logic [7:0] s);
		logic [3:0] n;
		n = 4'd1;
		if (m[7:6] == 2'd3) begin
			n = 4'd1;
		end else if (m[7:6] == 2'd0 && m[2:0] == 3'd5) begin
			n = 4'd5;
		end else begin
			if (m[2:0] == 3'd4) begin
				n = n + 4'd1;
				if (m[7:6] == 2'd0 && s[2:0] == 3'd5) n = n + 4'd4;
			end
			if (m[7:6] == 2'd1) n = n + 4'd1;
			if (m[7:6] == 2'd2) n = n + 4'd4;
		end
		return n;
	endfunction

	function automatic logic legacy_prefix(input logic [7:0] b);
		return b == PFX_LOCK || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
			b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 || b == PFX_OSZ ||
			b == PFX_ASZ;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/xild_lane.sv */
// One decode lane: classifies the window byte at its position.
`default_nettype none
module xild_lane (
	input  wire logic [7:0]          cur,
	input  wire logic [7:0]          nxt,
	output xild_pkg::lane_info_t     info
);
	always_comb begin
		info.is_prefix = xild_pkg::legacy_prefix(cur);
		info.is_osz    = cur == xild_pkg::PFX_OSZ;
		info.is_asz    = cur == xild_pkg::PFX_ASZ;
		info.is_rex    = cur[7:4] == 4'h4;
		info.rex_w     = cur[3];
		info.modrm_len = xild_pkg::modrm_size(cur, nxt);
	end
endmodule
`default_nettype wire

/* hw/rtl/xild_merge.sv */
// Merging stage: walks prefixes over registered lane results and sizes the instruction.
`default_nettype none
module xild_merge (
	input  wire logic [xild_pkg::WIN_BITS-1:0] win,
	input  wire xild_pkg::lane_vec_t           lanes,
	input  wire logic                          long_mode,
	output logic [3:0]                         len
);
	logic [7:0] b [0:xild_pkg::NUM_LANES+3];
	logic [4:0] i;
	logic [4:0] p;
	logic       osz, asz, rexw, done, bad;
	logic [7:0] op, op2, vop, map;
	logic [5:0] n;
	logic [4:0] z;

	function automatic logic [3:0] ml(input xild_pkg::lane_vec_t l, input logic [4:0] k);
		if (k >= 5'd16) return 4'd1;
		return l[k[3:0]].modrm_len;
	endfunction

	always_comb begin
		for (int k = 0; k < xild_pkg::NUM_LANES + 4; k++) begin
			b[k] = 8'h00;
		end
		for (int k = 0; k < xild_pkg::WINDOW_BYTES; k++) begin
			b[k] = win[8*k +: 8];
		end
		// Prefix scan: first lane that is not a prefix ends the run.
		p = 5'd15;
		done = 1'b0;
		osz = 1'b0;
		asz = 1'b0;
		for (int k = 0; k < 15; k++) begin
			if (!done) begin
				if (lanes[k].is_prefix) begin
					osz = osz | lanes[k].is_osz;
					asz = asz | lanes[k].is_asz;
				end else begin
					p = 5'(k);
					done = 1'b1;
				end
			end
		end
		i = p;
		rexw = 1'b0;
		if (long_mode && lanes[p[3:0]].is_rex) begin
			rexw = lanes[p[3:0]].rex_w;
			i = i + 5'd1;
		end
		op = b[i];
		i = i + 5'd1;
		z = osz ? 5'd2 : 5'd4;
		op2 = b[i];
		vop = 8'h00;
		map = 8'h00;
		bad = 1'b0;
		n = 6'd0;
		if (!long_mode && op[7:4] == 4'h4) begin
			n = 6'(i);
		end else if ((op == xild_pkg::OP_VEX3 || op == xild_pkg::OP_VEX2) &&
				(long_mode || b[i][7:6] == 2'b11)) begin
			if (op == xild_pkg::OP_VEX3) begin
				map = {3'b000, b[i][4:0]};
				vop = b[i+2];
				n = 6'(i) + 6'd3 + 6'(ml(lanes, i + 5'd3));
			end else begin
				map = 8'd1;
				vop = b[i+1];
				n = 6'(i) + 6'd2 + 6'(ml(lanes, i + 5'd2));
			end
			if (map == 8'd3 || (map == 8'd1 && (vop == 8'hC2 || vop == 8'hC4 ||
					vop == 8'hC5 || vop == 8'hC6 || (vop >= 8'h70 && vop <= 8'h73) ||
					vop == 8'hA4 || vop == 8'hAC)))
				n = n + 6'd1;
		end else if (op == xild_pkg::OP_TWO_BYTE) begin
			if (op2 == xild_pkg::OP_MAP38)
				n = 6'(i) + 6'd2 + 6'(ml(lanes, i + 5'd2));
			else if (op2 == xild_pkg::OP_MAP3A)
				n = 6'(i) + 6'd3 + 6'(ml(lanes, i + 5'd2));
			else if (op2 >= 8'h80 && op2 <= 8'h8F)
				n = 6'(i) + 6'd5;
			else if ((op2 >= 8'hC8 && op2 <= 8'hCF) || (op2 >= 8'h05 && op2 <= 8'h09) ||
					op2 == 8'h0B || op2 == 8'h31 || op2 == 8'h34 || op2 == 8'h35 ||
					op2 == 8'hA2)
				n = 6'(i) + 6'd1;
			else if ((op2 >= 8'h70 && op2 <= 8'h73) || op2 == 8'hC2 || op2 == 8'hC4 ||
					op2 == 8'hC5 || op2 == 8'hC6 || op2 == 8'hA4 || op2 == 8'hAC ||
					op2 == 8'hBA)
				n = 6'(i) + 6'd2 + 6'(ml(lanes, i + 5'd1));
			else if ((op2 >= 8'h10 && op2 <= 8'h2F) || (op2 >= 8'h40 && op2 <= 8'h6F) ||
					(op2 >= 8'h74 && op2 <= 8'h7F) || (op2 >= 8'h90 && op2 <= 8'h9F) ||
					(op2 >= 8'hA3 && op2 <= 8'hBF) || op2 == 8'hC0 || op2 == 8'hC1 ||
					op2 == 8'hC7 || op2 >= 8'hD0 || op2 == 8'h0D || op2 == 8'h0E)
				n = 6'(i) + 6'd1 + 6'(ml(lanes, i + 5'd1));
			else
				bad = 1'b1;
		end else if (op == 8'hE8 || op == 8'hE9) begin
			n = 6'(i) + 6'd4;
		end else if (op == 8'hEB || (op >= 8'h70 && op <= 8'h7F) ||
				(op >= 8'hE0 && op <= 8'hE3)) begin
			n = 6'(i) + 6'd1;
		end else if (op == 8'h90 || op == 8'hC3 || op == 8'hCB || op == 8'hC9 ||
				op == 8'hCC || op == 8'hCF || op == 8'hF4 || op == 8'hF5 ||
				(op >= 8'h50 && op <= 8'h5F) || (op >= 8'h91 && op <= 8'h99) ||
				(op >= 8'h9C && op <= 8'h9F) || (op >= 8'hF8 && op <= 8'hFD)) begin
			n = 6'(i);
		end else if (op == 8'hCD || (op >= 8'hE4 && op <= 8'hE7)) begin
			n = 6'(i) + 6'd1;
		end else if (op == 8'h68) begin
			n = 6'(i) + 6'(z);
		end else if (op == 8'h6A) begin
			n = 6'(i) + 6'd1;
		end else if (op == 8'hC2 || op == 8'hCA) begin
			n = 6'(i) + 6'd2;
		end else if (op == 8'hC8) begin
			n = 6'(i) + 6'd3;
		end else if (op >= 8'hA0 && op <= 8'hA3) begin
			if (long_mode) n = 6'(i) + (asz ? 6'd4 : 6'd8);
			else n = 6'(i) + (asz ? 6'd2 : 6'd4);
		end else if (op == 8'hA8) begin
			n = 6'(i) + 6'd1;
		end else if (op == 8'hA9) begin
			n = 6'(i) + 6'(z);
		end else if (op <= xild_pkg::OP_LAST_ALU && op[2:0] == 3'd4) begin
			n = 6'(i) + 6'd1;
		end else if (op <= xild_pkg::OP_LAST_ALU && op[2:0] == 3'd5) begin
			n = 6'(i) + 6'(z);
		end else if (op >= 8'hB0 && op <= 8'hB7) begin
			n = 6'(i) + 6'd1;
		end else if (op >= 8'hB8 && op <= 8'hBF) begin
			n = 6'(i) + (rexw ? 6'd8 : 6'(z));
		end else if (op == 8'hC6 || op == 8'h80 || op == 8'h82 || op == 8'h83 ||
				op == 8'h6B || op == 8'hC0 || op == 8'hC1) begin
			n = 6'(i) + 6'(ml(lanes, i)) + 6'd1;
		end else if (op == 8'hC7 || op == 8'h81 || op == 8'h69) begin
			n = 6'(i) + 6'(ml(lanes, i)) + 6'(z);
		end else if (op == xild_pkg::OP_GRP3B || op == xild_pkg::OP_GRP3V) begin
			n = 6'(i) + 6'(ml(lanes, i));
			if (b[i][5:3] == 3'd0)
				n = n + ((op == xild_pkg::OP_GRP3B) ? 6'd1 : 6'(z));
		end else if ((op <= 8'h3B && op[2:0] <= 3'd3) || op == 8'h62 || op == 8'h63 ||
				(op >= 8'h80 && op <= 8'h8F) || (!long_mode && (op == 8'hC4 ||
				op == 8'hC5)) || (op >= 8'hD0 && op <= 8'hD3) ||
				(op >= 8'hD8 && op <= 8'hDF) || op == 8'hFE || op == 8'hFF) begin
			n = 6'(i) + 6'(ml(lanes, i));
		end else begin
			bad = 1'b1;
		end
		if (bad || n > 6'(xild_pkg::WINDOW_BYTES) || n > 6'd15) len = 4'd0;
		else len = n[3:0];
	end
endmodule
`default_nettype wire

/* hw/rtl/x86_instruction_length_decoder.sv */
// Top level of the x86 / x64 instruction length decoder with its APB register.
// For each command, sixteen lanes classify every window byte in parallel and the results are
// registered with the window when start is accepted; from those registers the merging stage
// walks the prefixes and opcode maps, and the length is registered onto insn_length with done
// high for one cycle. busy is set by an accepted start and cleared when done rises, and a start
// while busy is ignored. The receiver cannot stall; results must be taken when done is high.
`default_nettype none
module x86_instruction_length_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] window_low,
	input  wire logic [55:0] window_high,
	output logic             done,
	output logic [3:0]       insn_length,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic                          long_mode_q;
	logic                          pend_s1;
	logic [xild_pkg::WIN_BITS-1:0] win_s1;
	logic [xild_pkg::WIN_BITS-1:0] win_in;
	logic [xild_pkg::WIN_BITS+7:0] win_pad;
	xild_pkg::lane_vec_t           lanes_in;
	xild_pkg::lane_vec_t           lanes_s1;
	logic [3:0]                    len;
	logic                          accept;

	assign pready = 1'b1;
	assign prdata = (paddr == xild_pkg::REG_LONG_MODE) ? {31'd0, long_mode_q} : 32'd0;
	assign busy = pend_s1;
	assign accept = start && !busy;
	assign win_in = {8'h00, window_high, window_low};
	assign win_pad = {8'h00, win_in};

	for (genvar g = 0; g < xild_pkg::NUM_LANES; g++) begin : g_lane
		xild_lane u_lane (
			.cur  (win_in[8*g +: 8]),
			.nxt  (win_pad[8*g+8 +: 8]),
			.info (lanes_in[g])
		);
	end

	xild_merge u_merge (
		.win       (win_s1),
		.lanes     (lanes_s1),
		.long_mode (long_mode_q),
		.len       (len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_mode_q <= 1'b1;
			pend_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == xild_pkg::REG_LONG_MODE)
				long_mode_q <= pwdata[0];
			pend_s1 <= accept;
			done <= pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1 <= win_in;
			lanes_s1 <= lanes_in;
		end
		if (pend_s1) insn_length <= len;
	end
endmodule
`default_nettype wire
